>>> rtl/svm_wps_pkg.sv
package svm_wps_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int OUT_IDX_W    = 12;
    localparam int CFG_W        = 31;
    localparam int DIVIDEND_W   = 64;
    localparam int DIVISOR_W    = 34;

    // operation codes
    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    // bound state codes
    localparam logic [1:0] BS_LOWER = 2'd0;
    localparam logic [1:0] BS_UPPER = 2'd1;
    localparam logic [1:0] BS_FREE  = 2'd2;

    // configuration register indexes
    localparam logic CFG_STOP_TOL  = 1'b0;
    localparam logic CFG_TAU_FLOOR = 1'b1;

    typedef struct packed {
        logic               op;
        logic               label_positive;
        logic [1:0]         bound_state;
        logic signed [31:0] gradient;
        logic signed [31:0] kernel_diag;
        logic signed [31:0] kernel_pos_row;
        logic signed [31:0] kernel_neg_row;
        logic signed [31:0] kernel_pos_self;
        logic signed [31:0] kernel_neg_self;
        logic               last;
    } t_in;

    typedef struct packed {
        logic                 kind;
        logic [OUT_IDX_W-1:0] pos_index;
        logic                 pos_found;
        logic [OUT_IDX_W-1:0] neg_index;
        logic                 neg_found;
        logic                 optimal;
        logic [OUT_IDX_W-1:0] pair_first;
        logic [OUT_IDX_W-1:0] pair_second;
        logic                 pair_found;
    } t_out;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

endpackage

>>> rtl/svm_wps_div.sv
module svm_wps_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  svm_wps_pkg::t_div_req             i_req,
    output logic                              o_done,
    output logic [svm_wps_pkg::DIVIDEND_W-1:0] o_quotient
);
    import svm_wps_pkg::*;

    localparam int STEPS = DIVIDEND_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIVISOR_W:0]    w_t1, w_t2;
    logic [DIVISOR_W-1:0]  w_r1;
    logic                  w_b1, w_b2;

    // two restoring steps per cycle (radix 4)
    always_comb begin
        w_t1 = {r_rem, r_quo[DIVIDEND_W-1]};
        w_b1 = (w_t1 >= {1'b0, i_req.divisor});
        w_r1 = w_b1 ? DIVISOR_W'(w_t1 - {1'b0, i_req.divisor}) : w_t1[DIVISOR_W-1:0];
        w_t2 = {w_r1, r_quo[DIVIDEND_W-2]};
        w_b2 = (w_t2 >= {1'b0, i_req.divisor});
    end

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_b2 ? DIVISOR_W'(w_t2 - {1'b0, i_req.divisor}) : w_t2[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-3:0], w_b1, w_b2};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/svm_working_pair_select.sv
// result: the result register loads from the finish state after the last element's transfer;
// when an objective is needed the element first passes the multiply state, the radix-4
// divider steps and the divider done strobe before the finish state
// input: one element at a time, stalled until the sequencer is back in idle
// a last element waits in the finish state while the previous result is still stalled
// reset (synchronous, active low) loads tolerance 66 and tau floor 1 and clears all scans
module svm_working_pair_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  svm_wps_pkg::t_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output svm_wps_pkg::t_out             o_out_data,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [svm_wps_pkg::CFG_W-1:0] i_cfg_data
);
    import svm_wps_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_stop_tol, r_tau;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic                 r_open, n_open;
    logic signed [32:0]   r_bpv, n_bpv, r_bnv, n_bnv;
    logic [IDX_W-1:0]     r_bpi, n_bpi, r_bni, n_bni;
    logic                 r_bpok, n_bpok, r_bnok, n_bnok;
    logic signed [32:0]   r_spm, n_spm, r_snm, n_snm;
    logic signed [63:0]   r_mobj, n_mobj;
    logic [IDX_W-1:0]     r_midx, n_midx;
    logic                 r_mok, n_mok, r_mlab, n_mlab;
    logic [31:0]          r_d, n_d;
    logic [DIVISOR_W-1:0] r_den, n_den;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_lab, n_lab, r_last, n_last, r_op, n_op;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic                 w_accept, w_at_lower, w_at_upper, w_cons;
    logic signed [32:0]   w_g, w_ng;
    logic signed [33:0]   w_dd, w_sp, w_sn;
    logic signed [34:0]   w_quad;
    logic signed [63:0]   w_obj;
    logic                 w_div_done;
    logic [DIVIDEND_W-1:0] w_quo;
    t_div_req             w_req;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_at_lower = (i_in_data.bound_state == BS_LOWER);
    assign w_at_upper = (i_in_data.bound_state == BS_UPPER);
    assign w_g        = 33'(i_in_data.gradient);
    assign w_ng       = -w_g;

    // one divider instance, dividend straight from the squaring multiplier
    assign w_req.start    = (r_state == S_MUL);
    assign w_req.dividend = 64'(r_d) * 64'(r_d);
    assign w_req.divisor  = r_den;

    svm_wps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_obj = w_quo[63] ? {1'b1, 63'd0} : -$signed(w_quo);
    assign w_sp  = 34'(r_bpv) + 34'(r_spm);
    assign w_sn  = 34'(r_bnv) + 34'(r_snm);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;   n_open = r_open;
        n_bpv = r_bpv;   n_bpi = r_bpi;   n_bpok = r_bpok;
        n_bnv = r_bnv;   n_bni = r_bni;   n_bnok = r_bnok;
        n_spm = r_spm;   n_snm = r_snm;
        n_mobj = r_mobj; n_midx = r_midx; n_mok = r_mok; n_mlab = r_mlab;
        n_d = r_d;       n_den = r_den;   n_idx = r_idx;
        n_lab = r_lab;   n_last = r_last; n_op = r_op;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        w_dd = '0;
        w_quad = '0;
        w_cons = 1'b0;
        case (r_state)
            // element transfer: bests, maxima, objective operands
            S_IDLE: begin
                if (w_accept) begin
                    if (!r_open) begin
                        if (i_in_data.op == OP_FIRST) begin
                            n_bpv = '0; n_bpi = '0; n_bpok = 1'b0;
                            n_bnv = '0; n_bni = '0; n_bnok = 1'b0;
                        end else begin
                            n_spm = {1'b1, 32'd0}; n_snm = {1'b1, 32'd0};
                            n_mobj = {1'b0, {63{1'b1}}};
                            n_midx = '0; n_mok = 1'b0; n_mlab = 1'b0;
                        end
                    end
                    if (i_in_data.op == OP_FIRST) begin
                        if (i_in_data.label_positive) begin
                            if (!w_at_upper && (!n_bpok || w_ng >= n_bpv)) begin
                                n_bpv = w_ng; n_bpi = r_cnt; n_bpok = 1'b1;
                            end
                        end else if (!w_at_lower && (!n_bnok || w_g >= n_bnv)) begin
                            n_bnv = w_g; n_bni = r_cnt; n_bnok = 1'b1;
                        end
                    end else if (i_in_data.label_positive) begin
                        if (!w_at_lower) begin
                            if (w_g >= n_spm) n_spm = w_g;
                            w_dd   = 34'(n_bpv) + 34'(w_g);
                            w_cons = n_bpok && (w_dd > 0);
                            w_quad = 35'(i_in_data.kernel_pos_self) + 35'(i_in_data.kernel_diag)
                                   - (35'(i_in_data.kernel_pos_row) <<< 1);
                        end
                    end else if (!w_at_upper) begin
                        if (w_ng >= n_snm) n_snm = w_ng;
                        w_dd   = 34'(n_bnv) - 34'(w_g);
                        w_cons = n_bnok && (w_dd > 0);
                        w_quad = 35'(i_in_data.kernel_neg_self) + 35'(i_in_data.kernel_diag)
                               - (35'(i_in_data.kernel_neg_row) <<< 1);
                    end
                    n_d = w_dd[31:0];
                    if (w_quad > 0) begin
                        n_den = w_quad[DIVISOR_W-1:0];
                    end else if (r_tau == '0) begin
                        n_den = DIVISOR_W'(1);
                    end else begin
                        n_den = DIVISOR_W'(r_tau);
                    end
                    n_open = 1'b1;
                    n_idx  = r_cnt;
                    n_lab  = i_in_data.label_positive;
                    n_last = i_in_data.last;
                    n_op   = i_in_data.op;
                    n_cnt  = (r_cnt == IDX_W'(MAX_ELEMENTS - 1)) ? '0 : r_cnt + 1'b1;
                    n_state = w_cons ? S_MUL : S_FIN;
                end
            end
            S_MUL: n_state = S_DIV;
            // objective compare, later element wins ties
            S_DIV: begin
                if (w_div_done) begin
                    if (w_obj <= r_mobj) begin
                        n_mobj = w_obj; n_midx = r_idx; n_mok = 1'b1; n_mlab = r_lab;
                    end
                    n_state = S_FIN;
                end
            end
            // return to idle, or after the last element close the scan and load the result register
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out = '0;
                    n_out.pos_index = OUT_IDX_W'(r_bpi);
                    n_out.pos_found = r_bpok;
                    n_out.neg_index = OUT_IDX_W'(r_bni);
                    n_out.neg_found = r_bnok;
                    if (r_op == OP_SECOND) begin
                        n_out.kind = 1'b1;
                        if (!(r_bpok && w_sp >= $signed({3'b000, r_stop_tol}))
                            && !(r_bnok && w_sn >= $signed({3'b000, r_stop_tol}))) begin
                            n_out.optimal = 1'b1;
                        end else if (r_mok) begin
                            n_out.pair_first  = OUT_IDX_W'(r_mlab ? r_bpi : r_bni);
                            n_out.pair_second = OUT_IDX_W'(r_midx);
                            n_out.pair_found  = 1'b1;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_cnt   = '0;
                    n_open  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stop_tol <= CFG_W'(66);
            r_tau <= CFG_W'(1);
            r_cnt <= '0;   r_open <= 1'b0;
            r_bpv <= '0;   r_bpi <= '0;   r_bpok <= 1'b0;
            r_bnv <= '0;   r_bni <= '0;   r_bnok <= 1'b0;
            r_spm <= {1'b1, 32'd0};
            r_snm <= {1'b1, 32'd0};
            r_mobj <= {1'b0, {63{1'b1}}};
            r_midx <= '0;  r_mok <= 1'b0; r_mlab <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == CFG_STOP_TOL) r_stop_tol <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_TAU_FLOOR) r_tau <= i_cfg_data;
            r_cnt <= n_cnt;   r_open <= n_open;
            r_bpv <= n_bpv;   r_bpi <= n_bpi;   r_bpok <= n_bpok;
            r_bnv <= n_bnv;   r_bni <= n_bni;   r_bnok <= n_bnok;
            r_spm <= n_spm;   r_snm <= n_snm;
            r_mobj <= n_mobj; r_midx <= n_midx; r_mok <= n_mok; r_mlab <= n_mlab;
            r_out_valid <= n_out_valid;
        end
        r_d <= n_d;       r_den <= n_den;   r_idx <= n_idx;
        r_lab <= n_lab;   r_last <= n_last; r_op <= n_op;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV) else $error("divider done outside wait");

    // an optimal answer carries no pair
    a_opt_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.optimal |-> !o_out_data.pair_found)
        else $error("optimal answer with pair");

    // a first scan report carries no decision
    a_first_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.kind |-> !o_out_data.optimal && !o_out_data.pair_found)
        else $error("first scan report with decision");

    // a pair needs a first-scan candidate
    a_pair_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pair_found |-> o_out_data.pos_found || o_out_data.neg_found)
        else $error("pair without candidate");

endmodule
